// ===== hw/rtl/rcpc_pkg.sv =====
// Shared types and constants for the ray / convex polyhedron clipper.
// No dependencies.
package rcpc_pkg;
  localparam int MaxFaces = 16;
  localparam int CntW = $clog2(MaxFaces + 1);
  localparam int DotW = 50;
  localparam int NumW = DotW + 16;
  localparam int QueueDepth = 2;

  // Face work handed from the front (dot products) to the back (divide, bounds).
  typedef struct packed {
    logic                   used;     // face takes part in the clip
    logic                   last;     // final face of the ray
    logic [CntW-1:0]        pos;      // face position in the ray
    logic signed [DotW-1:0] vd;
    logic signed [DotW-1:0] vn;
  } face_t;

  typedef enum logic [1:0] {
    BkIdle,
    BkDiv,
    BkUpd,
    BkOut
  } bk_state_e;
endpackage

// ===== hw/rtl/rcpc_front.sv =====
// Front part: forms vd and vn for one face over multiply steps.
// Depends on rcpc_pkg.
module rcpc_front import rcpc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic signed [31:0] origin_x_i,
  input  logic signed [31:0] origin_y_i,
  input  logic signed [31:0] origin_z_i,
  input  logic signed [31:0] dir_x_i,
  input  logic signed [31:0] dir_y_i,
  input  logic signed [31:0] dir_z_i,
  input  logic signed [31:0] plane_a_i,
  input  logic signed [31:0] plane_b_i,
  input  logic signed [31:0] plane_c_i,
  input  logic signed [31:0] plane_d_i,
  input  logic               face_valid_i,
  input  logic               last_face_i,
  output logic               q_valid_o,
  input  logic               q_ready_i,
  output face_t              q_data_o
);
  // One product per cycle; the step counter walks the six products and then
  // waits at step seven until the hand-off register is free.
  logic [2:0]              step_q, step_d;
  logic                    busy_q, busy_d;
  logic signed [31:0]      org_q [3];
  logic signed [31:0]      dir_q [3];
  logic signed [31:0]      nrm_q [3];
  logic signed [31:0]      pd_q;
  logic                    used_q, last_q;
  logic [CntW-1:0]         cnt_q, pos_q;
  logic signed [67:0]      acc_d_q, acc_n_q;
  logic signed [63:0]      prod;
  logic [1:0]              k;
  logic                    out_v_q;
  face_t                   out_q;

  assign ready_o = !busy_q && (!out_v_q || q_ready_i);
  assign k = step_q[1:0];
  assign prod = nrm_q[k] * (step_q[2] ? org_q[k] : dir_q[k]);

  // Step control.
  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    if (valid_i && ready_o) begin
      busy_d = 1'b1;
      step_d = 3'd0;
    end else if (busy_q) begin
      if (step_q == 3'd7) begin
        if (!out_v_q || q_ready_i) busy_d = 1'b0;
      end else if (step_q == 3'd2) begin
        step_d = 3'd4;
      end else begin
        step_d = step_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      step_q  <= 3'd0;
      out_v_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      if (busy_q && step_q == 3'd7 && (!out_v_q || q_ready_i)) out_v_q <= 1'b1;
      else if (q_ready_i) out_v_q <= 1'b0;
      if (valid_i && ready_o) begin
        if (last_face_i) cnt_q <= '0;
        else if (cnt_q < CntW'(MaxFaces)) cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Payload capture and accumulation; the sum of full products is exact.
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      org_q <= '{origin_x_i, origin_y_i, origin_z_i};
      dir_q <= '{dir_x_i, dir_y_i, dir_z_i};
      nrm_q <= '{plane_a_i, plane_b_i, plane_c_i};
      pd_q <= plane_d_i;
      used_q <= face_valid_i && (cnt_q < CntW'(MaxFaces));
      last_q <= last_face_i;
      pos_q <= cnt_q;
      acc_d_q <= '0;
      acc_n_q <= '0;
    end else if (busy_q && step_q != 3'd7) begin
      if (step_q[2]) acc_n_q <= acc_n_q + 68'(prod);
      else acc_d_q <= acc_d_q + 68'(prod);
    end
    if (busy_q && step_q == 3'd7 && (!out_v_q || q_ready_i)) begin
      out_q.used <= used_q;
      out_q.last <= last_q;
      out_q.pos  <= pos_q;
      out_q.vd   <= DotW'(acc_d_q >>> 16);
      out_q.vn   <= DotW'(acc_n_q >>> 16) + DotW'(pd_q);
    end
  end

  assign q_valid_o = out_v_q;
  assign q_data_o  = out_q;
endmodule

// ===== hw/rtl/rcpc_queue.sv =====
// Short queue of face work between front and back.
// Depends on rcpc_pkg.
module rcpc_queue import rcpc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_valid_i,
  output logic  wr_ready_o,
  input  face_t wr_data_i,
  output logic  rd_valid_o,
  input  logic  rd_ready_i,
  output face_t rd_data_o
);
  localparam int PtrW = $clog2(QueueDepth);
  face_t          mem_q [QueueDepth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [PtrW:0]   cnt_q;
  logic            wr, rd;

  assign wr_ready_o = cnt_q != (PtrW+1)'(QueueDepth);
  assign rd_valid_o = cnt_q != '0;
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 1'b1;
      if (rd) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(wr) - (PtrW+1)'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end
endmodule

// ===== hw/rtl/rcpc_back.sv =====
// Back part: restoring divider for t, bound update and result register.
// Depends on rcpc_pkg.
module rcpc_back import rcpc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  output logic               q_ready_o,
  input  face_t              q_data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic               hit_o,
  output logic signed [31:0] dist_in_o,
  output logic signed [31:0] dist_out_o,
  output logic signed [4:0]  face_in_o,
  output logic signed [4:0]  face_out_o
);
  localparam int StepW = $clog2(NumW + 1);
  bk_state_e st_q, st_d;
  face_t     f_q;
  logic [NumW-1:0] quo_q, rem_q, den_q;
  logic [StepW-1:0] n_q;
  logic signed [31:0] near_q, far_q;
  logic signed [4:0]  nf_q, ff_q;
  logic               miss_q;
  logic               neg;
  logic signed [31:0] t;
  logic [NumW:0]      trial;
  logic               take, par;
  logic               r_hit;
  logic signed [4:0]  r_fin, r_fout;

  assign par  = f_q.vd == '0;
  assign neg  = f_q.vn[DotW-1] == f_q.vd[DotW-1] && f_q.vn != '0;
  assign take = q_valid_i && st_q == BkIdle;
  assign q_ready_o = st_q == BkIdle;
  assign trial = {rem_q, quo_q[NumW-1]} - {1'b0, den_q};

  // Saturate quotient to the sentinels.
  always_comb begin
    if (neg) t = (quo_q > NumW'(32'h8000_0000)) ? 32'sh8000_0000 : -quo_q[31:0];
    else t = (quo_q > NumW'(32'h7fff_ffff)) ? 32'sh7fff_ffff : quo_q[31:0];
  end

  // Next state.
  always_comb begin
    st_d = st_q;
    case (st_q)
      BkIdle: if (take) st_d = BkDiv;
      BkDiv: begin
        if (!f_q.used || miss_q || par) st_d = BkUpd;
        else if (n_q == StepW'(NumW - 1)) st_d = BkUpd;
      end
      BkUpd: st_d = f_q.last ? BkOut : BkIdle;
      BkOut: if (!valid_o || ready_i) st_d = BkIdle;
      default: st_d = BkIdle;
    endcase
  end

  // Result decision.
  always_comb begin
    r_hit = 1'b0;
    r_fin = -5'sd1;
    r_fout = -5'sd1;
    if (!miss_q) begin
      if (near_q > 0) begin
        if (near_q < far_q) begin
          r_hit = 1'b1;
          r_fin = nf_q;
          r_fout = ff_q;
        end
      end else if (far_q > 0) begin
        r_hit = 1'b1;
        r_fout = ff_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BkIdle;
      near_q <= 32'sh8000_0000;
      far_q <= 32'sh7fff_ffff;
      nf_q <= -5'sd1;
      ff_q <= -5'sd1;
      miss_q <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == BkUpd && f_q.used && !miss_q) begin
        if (par) begin
          if (!f_q.vn[DotW-1] && f_q.vn != '0) miss_q <= 1'b1;
        end else if (f_q.vd[DotW-1]) begin
          if (t > near_q) begin
            near_q <= t;
            nf_q <= 5'(f_q.pos);
          end
        end else if (t < far_q) begin
          far_q <= t;
          ff_q <= 5'(f_q.pos);
        end
      end
      if (st_q == BkOut && (!valid_o || ready_i)) begin
        valid_o <= 1'b1;
        near_q <= 32'sh8000_0000;
        far_q <= 32'sh7fff_ffff;
        nf_q <= -5'sd1;
        ff_q <= -5'sd1;
        miss_q <= 1'b0;
      end else if (ready_i) begin
        valid_o <= 1'b0;
      end
    end
  end

  // Divider datapath and result payload.
  always_ff @(posedge clk_i) begin
    if (take) begin
      f_q <= q_data_i;
      n_q <= '0;
      rem_q <= '0;
      quo_q <= NumW'(q_data_i.vn[DotW-1] ? -q_data_i.vn : q_data_i.vn) << 16;
      den_q <= NumW'(q_data_i.vd[DotW-1] ? -q_data_i.vd : q_data_i.vd);
    end else if (st_q == BkDiv) begin
      n_q <= n_q + 1'b1;
      if (!trial[NumW]) begin
        rem_q <= trial[NumW-1:0];
        quo_q <= {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[NumW-2:0], quo_q[NumW-1]};
        quo_q <= {quo_q[NumW-2:0], 1'b0};
      end
    end
    if (st_q == BkOut && (!valid_o || ready_i)) begin
      hit_o <= r_hit;
      dist_in_o <= near_q;
      dist_out_o <= far_q;
      face_in_o <= r_fin;
      face_out_o <= r_fout;
    end
  end
endmodule

// ===== hw/rtl/ray_convex_polyhedron_clip_core.sv =====
// Ray / convex polyhedron clipper, signed Q16.16.
// Front: per face, six serial products, then the hand-off register.
// Back: per used face, a restoring divide at one quotient bit per cycle over 66 bits;
// skipped, parallel or ignored faces leave the divide state without dividing and go on
// to the bound update, and the last face also passes through the result state.
// rst_ni clears all control state and the clip bounds asynchronously.
module ray_convex_polyhedron_clip_core import rcpc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic signed [31:0] origin_x_i,
  input  logic signed [31:0] origin_y_i,
  input  logic signed [31:0] origin_z_i,
  input  logic signed [31:0] dir_x_i,
  input  logic signed [31:0] dir_y_i,
  input  logic signed [31:0] dir_z_i,
  input  logic signed [31:0] plane_a_i,
  input  logic signed [31:0] plane_b_i,
  input  logic signed [31:0] plane_c_i,
  input  logic signed [31:0] plane_d_i,
  input  logic               face_valid_i,
  input  logic               last_face_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic               hit_o,
  output logic signed [31:0] dist_in_o,
  output logic signed [31:0] dist_out_o,
  output logic signed [4:0]  face_in_o,
  output logic signed [4:0]  face_out_o
);
  logic  fq_v, fq_r, bq_v, bq_r;
  face_t fq_d, bq_d;

  rcpc_front u_front (
    .clk_i, .rst_ni, .valid_i, .ready_o,
    .origin_x_i, .origin_y_i, .origin_z_i, .dir_x_i, .dir_y_i, .dir_z_i,
    .plane_a_i, .plane_b_i, .plane_c_i, .plane_d_i, .face_valid_i, .last_face_i,
    .q_valid_o(fq_v), .q_ready_i(fq_r), .q_data_o(fq_d)
  );

  rcpc_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(fq_v), .wr_ready_o(fq_r), .wr_data_i(fq_d),
    .rd_valid_o(bq_v), .rd_ready_i(bq_r), .rd_data_o(bq_d)
  );

  rcpc_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(bq_v), .q_ready_o(bq_r), .q_data_i(bq_d),
    .valid_o, .ready_i, .hit_o, .dist_in_o, .dist_out_o, .face_in_o, .face_out_o
  );
endmodule

// ===== hw/rtl/rcpc_checker.sv =====
// Port-level checks for the clipper core, bound to the top level.
// Depends on ray_convex_polyhedron_clip_core.
module rcpc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               valid_o,
  input logic               ready_i,
  input logic               hit_o,
  input logic signed [31:0] dist_in_o,
  input logic signed [4:0]  face_in_o,
  input logic signed [4:0]  face_out_o
);
  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(dist_in_o)) else $error("result dropped");
  // A miss reports no faces.
  a_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !hit_o |-> face_in_o == -5'sd1 && face_out_o == -5'sd1)
    else $error("miss with face");
  // An entry face implies a positive near distance.
  a_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && face_in_o != -5'sd1 |-> hit_o && dist_in_o > 0)
    else $error("bad entry face");
endmodule

bind ray_convex_polyhedron_clip_core rcpc_checker u_rcpc_checker (
  .clk_i, .rst_ni, .valid_o, .ready_i, .hit_o, .dist_in_o, .face_in_o, .face_out_o
);

// ===== sim/ray_convex_polyhedron_clip_core_tb.sv =====
// Testbench for the ray / convex polyhedron clipper core.
// Streams faces through the valid/ready input, predicts each ray result and checks it.
// Depends on rcpc_pkg and ray_convex_polyhedron_clip_core.
`timescale 1ns / 100ps

module ray_convex_polyhedron_clip_core_tb import rcpc_pkg::*;;

  localparam int WatchdogLimit = 20000;
  localparam int DrainCycles = 200;

  typedef struct {
    logic signed [31:0] org [3];
    logic signed [31:0] dir [3];
    logic signed [31:0] nrm [3];
    logic signed [31:0] d;
    logic               used;
    logic               last;
  } face_item_t;

  typedef struct {
    logic               hit;
    logic signed [31:0] dist_in;
    logic signed [31:0] dist_out;
    logic signed [4:0]  face_in;
    logic signed [4:0]  face_out;
  } clip_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic valid_in = 1'b0;
  logic ready_out;
  logic signed [31:0] ox = '0, oy = '0, oz = '0, dx = '0, dy = '0, dz = '0;
  logic signed [31:0] pa = '0, pb = '0, pc = '0, pd = '0;
  logic fvalid = 1'b0, flast = 1'b0;
  logic valid_out;
  logic ready_in = 1'b0;
  logic hit;
  logic signed [31:0] dist_in, dist_out;
  logic signed [4:0] face_in, face_out;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors = 0;
  int idle_cycles = 0;
  bit timed_out = 1'b0;

  clip_result_t expected_results [$];

  // Predicted clip bounds of the ray in flight.
  longint near_d, far_d, near_f, far_f;
  int face_pos;
  bit par_miss;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  ray_convex_polyhedron_clip_core u_top (
    .clk_i(clk), .rst_ni(rst_n), .valid_i(valid_in), .ready_o(ready_out),
    .origin_x_i(ox), .origin_y_i(oy), .origin_z_i(oz),
    .dir_x_i(dx), .dir_y_i(dy), .dir_z_i(dz),
    .plane_a_i(pa), .plane_b_i(pb), .plane_c_i(pc), .plane_d_i(pd),
    .face_valid_i(fvalid), .last_face_i(flast),
    .valid_o(valid_out), .ready_i(ready_in), .hit_o(hit),
    .dist_in_o(dist_in), .dist_out_o(dist_out),
    .face_in_o(face_in), .face_out_o(face_out)
  );

  function automatic void clear_bounds();
    near_d = -64'sd2147483648;
    far_d = 64'sd2147483647;
    near_f = -1;
    far_f = -1;
    face_pos = 0;
    par_miss = 1'b0;
  endfunction

  // Floor of an exact three-term dot product shifted down by 16 bits.
  function automatic longint dot_floor(logic signed [31:0] a [3], logic signed [31:0] b [3]);
    logic signed [127:0] acc;
    acc = 0;
    for (int k = 0; k < 3; k++) acc += 128'(longint'(a[k]) * longint'(b[k]));
    return longint'(acc >>> 16);
  endfunction

  // Distance -vn/vd in Q16.16, truncated toward zero and saturated.
  function automatic longint face_distance(longint vn, longint vd);
    logic [127:0] num, den, q;
    bit neg;
    neg = (vn > 0) != (vd < 0);
    num = 128'(vn < 0 ? -vn : vn) << 16;
    den = 128'(vd < 0 ? -vd : vd);
    q = num / den;
    if (neg) return (q > 128'h80000000) ? -64'sd2147483648 : -longint'(q);
    return (q > 128'h7FFFFFFF) ? 64'sd2147483647 : longint'(q);
  endfunction

  // Update the predicted bounds with one face and queue a result on the last one.
  function automatic void predict_face(face_item_t f);
    longint vd, vn, t;
    clip_result_t r;
    if (f.used && !par_miss && face_pos < MaxFaces) begin
      vd = dot_floor(f.nrm, f.dir);
      vn = dot_floor(f.nrm, f.org) + longint'(f.d);
      if (vd == 0) begin
        if (vn > 0) par_miss = 1'b1;
      end else begin
        t = face_distance(vn, vd);
        if (vd < 0) begin
          if (t > near_d) begin
            near_d = t;
            near_f = face_pos;
          end
        end else if (t < far_d) begin
          far_d = t;
          far_f = face_pos;
        end
      end
    end
    if (face_pos < MaxFaces) face_pos++;
    if (!f.last) return;
    r.hit = 1'b0;
    r.face_in = -5'sd1;
    r.face_out = -5'sd1;
    if (!par_miss) begin
      if (near_d > 0) begin
        if (near_d < far_d) begin
          r.hit = 1'b1;
          r.face_in = near_f[4:0];
          r.face_out = far_f[4:0];
        end
      end else if (far_d > 0) begin
        r.hit = 1'b1;
        r.face_out = far_f[4:0];
      end
    end
    r.dist_in = near_d[31:0];
    r.dist_out = far_d[31:0];
    expected_results = {expected_results, r};
    clear_bounds();
  endfunction

  // Drive one face and wait for its transfer; valid stays up until the
  // sender idles or the drain begins.
  task automatic send_face(face_item_t f);
    while ($urandom_range(99) < send_idle_pct) begin
      valid_in <= 1'b0;
      @(negedge clk);
    end
    ox <= f.org[0]; oy <= f.org[1]; oz <= f.org[2];
    dx <= f.dir[0]; dy <= f.dir[1]; dz <= f.dir[2];
    pa <= f.nrm[0]; pb <= f.nrm[1]; pc <= f.nrm[2]; pd <= f.d;
    fvalid <= f.used;
    flast <= f.last;
    valid_in <= 1'b1;
    @(posedge clk);
    while (!ready_out) @(posedge clk);
    predict_face(f);
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_word(int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
      2: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
    endcase
  endfunction

  // A ray whose faces share origin and direction, with random planes.
  task automatic send_ray(int nfaces, int mode);
    face_item_t f;
    for (int k = 0; k < 3; k++) begin
      f.org[k] = rand_word(mode);
      f.dir[k] = rand_word(mode);
    end
    for (int i = 0; i < nfaces; i++) begin
      for (int k = 0; k < 3; k++) f.nrm[k] = rand_word(mode);
      if ($urandom_range(9) == 0) begin
        // Normal perpendicular to the direction in x/y: a parallel face.
        f.nrm[0] = f.dir[1];
        f.nrm[1] = -f.dir[0];
        f.nrm[2] = 0;
      end
      f.d = rand_word(mode);
      f.used = $urandom_range(7) != 0;
      f.last = (i == nfaces - 1);
      send_face(f);
    end
  endtask

  // Check each result transfer against the oldest prediction.
  always @(posedge clk) begin
    clip_result_t e;
    if (rst_n && valid_out && ready_in) begin
      idle_cycles = 0;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result hit=%0d", $time, hit);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (hit !== e.hit) begin
          $display("%0t: hit exp %0d got %0d", $time, e.hit, hit);
          errors++;
        end
        if (dist_in !== e.dist_in) begin
          $display("%0t: dist_in exp %h got %h", $time, e.dist_in, dist_in);
          errors++;
        end
        if (dist_out !== e.dist_out) begin
          $display("%0t: dist_out exp %h got %h", $time, e.dist_out, dist_out);
          errors++;
        end
        if (face_in !== e.face_in) begin
          $display("%0t: face_in exp %0d got %0d", $time, e.face_in, face_in);
          errors++;
        end
        if (face_out !== e.face_out) begin
          $display("%0t: face_out exp %0d got %0d", $time, e.face_out, face_out);
          errors++;
        end
      end
    end else if (rst_n && valid_in && ready_out) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
  end

  // Receiver back-pressure.
  always @(negedge clk) ready_in <= ($urandom_range(99) >= recv_idle_pct);

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (idle_cycles >= WatchdogLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("Mismatches found");
      $finish;
    end
  end

  // Extremes, parallel faces inside and outside, skipped faces and overflow of the count.
  task automatic test_directed();
    face_item_t f;
    for (int k = 0; k < 3; k++) begin
      f.org[k] = 0;
      f.dir[k] = 0;
      f.nrm[k] = 0;
    end
    f.dir[0] = 32'sh0001_0000;
    // Box x in [-1, 2] along +x from the origin.
    f.nrm[0] = 32'sh0001_0000; f.d = -32'sh0002_0000; f.used = 1; f.last = 0;
    send_face(f);
    f.nrm[0] = -32'sh0001_0000; f.d = -32'sh0001_0000; f.last = 1;
    send_face(f);
    // Parallel face with origin inside, then outside (miss, later faces ignored).
    f.nrm[0] = 0; f.nrm[1] = 32'sh0001_0000; f.d = -32'sh0001_0000; f.last = 0;
    send_face(f);
    f.d = 32'sh0001_0000;
    send_face(f);
    f.nrm[0] = 32'sh0001_0000; f.nrm[1] = 0; f.last = 1;
    send_face(f);
    // Tiny normal that gives a vd of only one LSB.
    f.nrm[0] = 1; f.d = 5; f.last = 1;
    send_face(f);
    // All fields at their extremes, skipped face too.
    for (int k = 0; k < 3; k++) begin
      f.org[k] = 32'sh7FFF_FFFF;
      f.dir[k] = 32'sh8000_0000;
      f.nrm[k] = 32'sh8000_0000;
    end
    f.d = 32'sh8000_0000; f.used = 0; f.last = 0;
    send_face(f);
    f.used = 1;
    send_face(f);
    f.d = 32'sh7FFF_FFFF; f.nrm[1] = 32'sh7FFF_FFFF; f.last = 1;
    send_face(f);
    // More faces than the block records.
    send_ray(MaxFaces + 3, 1);
  endtask

  task automatic test_random(int nitems);
    int sent;
    int n;
    sent = 0;
    while (sent < nitems) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(MaxFaces + 4) + 1 : $urandom_range(6) + 1;
      send_ray(n, $urandom_range(3));
      sent += n;
    end
  endtask

  task automatic wait_drain();
    valid_in <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  initial begin
    clear_bounds();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 28;
    recv_idle_pct = 88;
    test_directed();
    test_random(600);
    send_idle_pct = 88;
    recv_idle_pct = 28;
    test_random(600);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(600);
    wait_drain();
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
hw/rtl/rcpc_pkg.sv
hw/rtl/rcpc_front.sv
hw/rtl/rcpc_queue.sv
hw/rtl/rcpc_back.sv
hw/rtl/ray_convex_polyhedron_clip_core.sv
hw/rtl/rcpc_checker.sv
sim/ray_convex_polyhedron_clip_core_tb.sv
